FILE: design/ipt_pkg.sv
// Shared types, constants and helpers for the inverted page table translator.
// Used by every module under design/.
package ipt_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int NF_W       = $clog2(MAX_FRAMES + 1);

  localparam int OP_W       = 1;
  localparam int FRAME_IN_W = 4;
  localparam int PAGE_W     = 16;
  localparam int LADDR_W    = 16;
  localparam int PS_W       = 13;
  localparam int FC_W       = 5;
  localparam int BASE_W     = 20;
  localparam int STATUS_W   = 2;
  localparam int PA_W       = 21;

  localparam int DIV_STEPS  = LADDR_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [1:0] REG_PAGE_SIZE   = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] REG_BASE_ADDR   = 2'd2;

  localparam logic [OP_W-1:0] OP_MAP       = 1'b0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 1'b1;

  localparam logic [1:0] KIND_MAP   = 2'd0;
  localparam logic [1:0] KIND_BAD   = 2'd1;
  localparam logic [1:0] KIND_XLATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAME  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FRAME_IN_W-1:0] frame;
    logic [PAGE_W-1:0]     page;
    logic [LADDR_W-1:0]    laddr;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [LADDR_W-1:0] dividend;
    logic [PS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LADDR_W-1:0] quotient;
    logic [PS_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [PS_W-1:0] eff_page_size(input logic [PS_W-1:0] ps);
    return (ps == '0) ? PS_W'(1) : ps;
  endfunction

  function automatic logic [NF_W-1:0] eff_frames(input logic [FC_W-1:0] fc);
    if (int'(fc) > MAX_FRAMES) begin
      return NF_W'(MAX_FRAMES);
    end
    return NF_W'(fc);
  endfunction

endpackage

FILE: design/ipt_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on ipt_pkg.
module ipt_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ipt_pkg::OP_W-1:0]        in_operation,
  input  logic [ipt_pkg::FRAME_IN_W-1:0]  in_frame_number,
  input  logic [ipt_pkg::PAGE_W-1:0]      in_page_number,
  input  logic [ipt_pkg::LADDR_W-1:0]     in_logical_address,
  input  logic [ipt_pkg::FC_W-1:0]        frame_count,
  output logic                            q_valid,
  output ipt_pkg::item_t                  q_item,
  input  logic                            q_pop
);

  localparam logic [ipt_pkg::QCNT_W-1:0] QCNT_ONE = ipt_pkg::QCNT_W'(1);
  localparam logic [ipt_pkg::QPTR_W-1:0] QPTR_ONE = ipt_pkg::QPTR_W'(1);

  ipt_pkg::item_t                  q_mem_r [ipt_pkg::QDEPTH];
  logic [ipt_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [ipt_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [ipt_pkg::QCNT_W-1:0]      cnt_r;
  logic [ipt_pkg::QCNT_W-1:0]      cnt_nxt;
  logic [ipt_pkg::NF_W-1:0]        nf;
  logic                            push;
  ipt_pkg::item_t                  item;

  assign nf       = ipt_pkg::eff_frames(frame_count);
  assign in_stall = (int'(cnt_r) == ipt_pkg::QDEPTH);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    item       = '0;
    item.frame = in_frame_number;
    item.page  = in_page_number;
    item.laddr = in_logical_address;
    if (in_operation == ipt_pkg::OP_TRANSLATE) begin
      item.kind = ipt_pkg::KIND_XLATE;
    end else if (int'(in_frame_number) >= int'(nf)) begin
      item.kind = ipt_pkg::KIND_BAD;
    end else begin
      item.kind = ipt_pkg::KIND_MAP;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_ONE;
    end else if (q_pop && !push) begin
      cnt_nxt = cnt_r - QCNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == ipt_pkg::QDEPTH - 1) ? '0 : wr_ptr_r + QPTR_ONE;
      end
      if (q_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == ipt_pkg::QDEPTH - 1) ? '0 : rd_ptr_r + QPTR_ONE;
      end
    end
  end

endmodule

FILE: design/ipt_div.sv
// Serial restoring divider: one quotient bit per cycle, splits an address into page and offset.
// Depends on ipt_pkg.
module ipt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ipt_pkg::div_req_t req,
  output ipt_pkg::div_rsp_t rsp
);

  logic [ipt_pkg::PS_W-1:0]    rem_r;
  logic [ipt_pkg::LADDR_W-1:0] quo_r;
  logic [ipt_pkg::PS_W-1:0]    den_r;
  logic [ipt_pkg::DCNT_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ipt_pkg::PS_W:0]      trial;
  logic                        take;
  logic [ipt_pkg::PS_W:0]      diff;

  assign trial = {rem_r, quo_r[ipt_pkg::LADDR_W-1]};
  assign take  = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= take ? diff[ipt_pkg::PS_W-1:0] : trial[ipt_pkg::PS_W-1:0];
      quo_r <= {quo_r[ipt_pkg::LADDR_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ipt_pkg::DCNT_W'(1);
        if (int'(cnt_r) == ipt_pkg::DIV_STEPS - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/ipt_back.sv
// Back end: frame table, lookup sequencer and result register.
// Depends on ipt_pkg and ipt_div.
module ipt_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  ipt_pkg::item_t                 q_item,
  output logic                           q_pop,
  input  logic [ipt_pkg::PS_W-1:0]       page_size,
  input  logic [ipt_pkg::FC_W-1:0]       frame_count,
  input  logic [ipt_pkg::BASE_W-1:0]     base_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ipt_pkg::STATUS_W-1:0]   out_status,
  output logic [ipt_pkg::PA_W-1:0]       out_physical_address
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MATCH = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_CALC  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int PROD_W = ipt_pkg::FRAME_W + ipt_pkg::PS_W;

  logic [2:0]                         state_r, state_nxt;
  logic [ipt_pkg::PAGE_W-1:0]         page_r, page_nxt;
  logic [ipt_pkg::PS_W-1:0]           offset_r, offset_nxt;
  logic [ipt_pkg::MAX_FRAMES-1:0]     match_r, match_nxt;
  logic                               hit_r, hit_nxt;
  logic [ipt_pkg::FRAME_W-1:0]        frame_r, frame_nxt;
  logic [ipt_pkg::PA_W-1:0]           prod_r, prod_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [ipt_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic [ipt_pkg::PA_W-1:0]           out_pa_r, out_pa_nxt;

  logic [ipt_pkg::PAGE_W-1:0]         frame_page_r [ipt_pkg::MAX_FRAMES];
  logic [ipt_pkg::MAX_FRAMES-1:0]     frame_valid_r;

  logic [ipt_pkg::PS_W-1:0]           ps;
  logic [ipt_pkg::NF_W-1:0]           nf;
  logic                               out_free;
  logic [ipt_pkg::MAX_FRAMES-1:0]     match_w;
  logic [ipt_pkg::FRAME_W-1:0]        lowest;
  logic [PROD_W-1:0]                  prod_w;
  logic [ipt_pkg::PA_W-1:0]           sum_w;
  logic [ipt_pkg::FRAME_W-1:0]        wr_idx;
  logic                               wr_en;
  ipt_pkg::div_req_t                  div_req;
  ipt_pkg::div_rsp_t                  div_rsp;

  ipt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign ps       = ipt_pkg::eff_page_size(page_size);
  assign nf       = ipt_pkg::eff_frames(frame_count);
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign wr_en    = q_pop && (q_item.kind == ipt_pkg::KIND_MAP);
  assign wr_idx   = ipt_pkg::FRAME_W'(q_item.frame);

  assign div_req.start    = q_pop && (q_item.kind == ipt_pkg::KIND_XLATE);
  assign div_req.dividend = q_item.laddr;
  assign div_req.divisor  = ps;

  assign prod_w = PROD_W'(frame_r) * PROD_W'(ps);
  assign sum_w  = ipt_pkg::PA_W'(base_address) + prod_r + ipt_pkg::PA_W'(offset_r);

  always_comb begin
    for (int i = 0; i < ipt_pkg::MAX_FRAMES; i++) begin
      match_w[i] = frame_valid_r[i] && (frame_page_r[i] == page_r) && (i < int'(nf));
    end
  end

  always_comb begin
    lowest = '0;
    for (int i = ipt_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        lowest = ipt_pkg::FRAME_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    offset_nxt     = offset_r;
    match_nxt      = match_r;
    hit_nxt        = hit_r;
    frame_nxt      = frame_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pa_nxt     = out_pa_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          case (q_item.kind)
            ipt_pkg::KIND_MAP: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ipt_pkg::ST_OK;
              out_pa_nxt     = '0;
            end
            ipt_pkg::KIND_XLATE: begin
              state_nxt = S_DIV;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ipt_pkg::ST_BAD_FRAME;
              out_pa_nxt     = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          page_nxt   = div_rsp.quotient;
          offset_nxt = div_rsp.remainder;
          state_nxt  = S_MATCH;
        end
      end
      S_MATCH: begin
        match_nxt = match_w;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        hit_nxt   = |match_r;
        frame_nxt = lowest;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        prod_nxt  = ipt_pkg::PA_W'(prod_w);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = hit_r ? ipt_pkg::ST_OK : ipt_pkg::ST_NOT_MAPPED;
        out_pa_nxt     = hit_r ? sum_w : '0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    offset_r     <= offset_nxt;
    match_r      <= match_nxt;
    hit_r        <= hit_nxt;
    frame_r      <= frame_nxt;
    prod_r       <= prod_nxt;
    out_status_r <= out_status_nxt;
    out_pa_r     <= out_pa_nxt;
    if (wr_en) begin
      frame_page_r[wr_idx] <= q_item.page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      frame_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        frame_valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_pa_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> !out_valid_r)
    else $error("translate result would overwrite a pending beat");

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_valid_r && state_r == S_IDLE)
    else $error("translate finished without a result beat");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ipt_pkg::ST_OK |-> out_pa_r == '0)
    else $error("failed item carries a nonzero address");

endmodule

FILE: design/inverted_page_table_translate.sv
// Inverted page table translator. A map beat loads a page into a frame of a 16-entry
// table (cleared at reset through per-frame valid bits, no clearing pass); a map or
// out-of-range beat is answered in the cycle after the back end takes it. A translate beat
// is answered after the bit-serial divider that splits the address by the page size, a
// step to take the quotient, then table compare, lowest-frame pick, frame-times-page-size
// multiply and the final sum; the back end then returns to idle and takes its next beat
// once its result slot is free. A two-entry queue keeps accepting beats meanwhile until full.
// Depends on ipt_pkg, ipt_front, ipt_back and ipt_div.
module inverted_page_table_translate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ipt_pkg::OP_W-1:0]        in_operation,
  input  logic [ipt_pkg::FRAME_IN_W-1:0]  in_frame_number,
  input  logic [ipt_pkg::PAGE_W-1:0]      in_page_number,
  input  logic [ipt_pkg::LADDR_W-1:0]     in_logical_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ipt_pkg::STATUS_W-1:0]    out_status,
  output logic [ipt_pkg::PA_W-1:0]        out_physical_address,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ipt_pkg::PADDR_W-1:0]     paddr,
  input  logic [ipt_pkg::PDATA_W-1:0]     pwdata,
  output logic [ipt_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [ipt_pkg::PS_W-1:0]   page_size_r;
  logic [ipt_pkg::FC_W-1:0]   frame_count_r;
  logic [ipt_pkg::BASE_W-1:0] base_r;
  logic [1:0]                 reg_idx;
  logic                       wr;
  logic                       q_valid;
  logic                       q_pop;
  ipt_pkg::item_t             q_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r   <= ipt_pkg::PS_W'(1);
      frame_count_r <= ipt_pkg::FC_W'(16);
      base_r        <= '0;
    end else if (wr) begin
      case (reg_idx)
        ipt_pkg::REG_PAGE_SIZE:   page_size_r   <= pwdata[ipt_pkg::PS_W-1:0];
        ipt_pkg::REG_FRAME_COUNT: frame_count_r <= pwdata[ipt_pkg::FC_W-1:0];
        ipt_pkg::REG_BASE_ADDR:   base_r        <= pwdata[ipt_pkg::BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ipt_pkg::REG_PAGE_SIZE:   prdata = ipt_pkg::PDATA_W'(page_size_r);
      ipt_pkg::REG_FRAME_COUNT: prdata = ipt_pkg::PDATA_W'(frame_count_r);
      ipt_pkg::REG_BASE_ADDR:   prdata = ipt_pkg::PDATA_W'(base_r);
      default:                  prdata = '0;
    endcase
  end

  ipt_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_frame_number    (in_frame_number),
    .in_page_number     (in_page_number),
    .in_logical_address (in_logical_address),
    .frame_count        (frame_count_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  ipt_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .page_size            (page_size_r),
    .frame_count          (frame_count_r),
    .base_address         (base_r),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_physical_address (out_physical_address)
  );

endmodule
